>>> rtl/sab_pkg.sv
`default_nettype none
package sab_pkg;

	// blend action codes
	localparam logic ACT_LUMA   = 1'b0;
	localparam logic ACT_CHROMA = 1'b1;

	// full weight of the blend
	localparam logic [7:0] BLEND_FULL = 8'd255;

	// rgb to yuv coefficients, scaled by 1024
	localparam int CY_R = 263;
	localparam int CY_G = 516;
	localparam int CY_B = 100;
	localparam int CU_R = 450;
	localparam int CU_G = 376;
	localparam int CU_B = 73;
	localparam int CV_R = 152;
	localparam int CV_G = 298;
	localparam int CV_B = 450;

	// offsets added after the scale-down
	localparam logic [7:0] Y_OFFSET = 8'd16;
	localparam logic [7:0] C_OFFSET = 8'd128;

	// input beat
	typedef struct packed {
		logic        action;
		logic [31:0] overlay_color;
		logic [7:0]  coverage_a;
		logic [7:0]  coverage_b;
		logic [7:0]  coverage_c;
		logic [7:0]  coverage_d;
		logic [7:0]  pixel_luma;
		logic [7:0]  pixel_cb;
		logic [7:0]  pixel_cr;
	} sab_item_t;

	// result beat
	typedef struct packed {
		logic [7:0] out_luma;
		logic [7:0] out_cb;
		logic [7:0] out_cr;
	} sab_result_t;

	// overlay colour in yuv
	typedef struct packed {
		logic [7:0] y;
		logic [7:0] u;
		logic [7:0] v;
	} sab_yuv_t;

	// floor(x / 255), exact for x up to 255 * 255
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + 17'(x[15:8]) + 17'd1;
		return t[15:8];
	endfunction

endpackage
`default_nettype wire

>>> rtl/sab_rgb2yuv.sv
`default_nettype none
module sab_rgb2yuv
	import sab_pkg::*;
(
	input  wire logic        clk,
	input  wire logic [31:0] color,
	output sab_yuv_t         yuv_s2
);

	logic        [7:0]  r, g, b;
	logic signed [18:0] sr, sg, sb;
	logic        [17:0] sum_y;
	logic signed [18:0] sum_u, sum_v;

	logic        [17:0] sum_y_s1;
	logic signed [18:0] sum_u_s1, sum_v_s1;

	assign r  = color[31:24];
	assign g  = color[23:16];
	assign b  = color[15:8];
	assign sr = signed'({11'd0, r});
	assign sg = signed'({11'd0, g});
	assign sb = signed'({11'd0, b});

	// constant products and sums of the matrix
	always_comb begin
		sum_y = 18'(CY_R) * 18'(r) + 18'(CY_G) * 18'(g) + 18'(CY_B) * 18'(b);
		sum_u = 19'(CU_R) * sr - 19'(CU_G) * sg - 19'(CU_B) * sb;
		sum_v = 19'(CV_B) * sb - 19'(CV_R) * sr - 19'(CV_G) * sg;
	end

	// stage 1: matrix sums
	always_ff @(posedge clk) begin
		sum_y_s1 <= sum_y;
		sum_u_s1 <= sum_u;
		sum_v_s1 <= sum_v;
	end

	// stage 2: floor scale-down and offset, wrapped to a byte
	always_ff @(posedge clk) begin
		yuv_s2.y <= sum_y_s1[17:10] + Y_OFFSET;
		yuv_s2.u <= sum_u_s1[17:10] + C_OFFSET;
		yuv_s2.v <= sum_v_s1[17:10] + C_OFFSET;
	end

endmodule
`default_nettype wire

>>> rtl/subtitle_alpha_blend_yuv.sv
`default_nettype none
// Subtitle glyph blend into a 4:2:0 picture. A beat is taken at every clock
// edge where start is high; busy is held low, so one beat per clock is
// sustained. Each result appears on result for one cycle with done high,
// after its beat has passed the five register stages (coverage and matrix
// sums, weight product and overlay colour, weight divide, the two blend
// products, final divide), in order; the receiver cannot stall. Action 0
// blends luma with coverage_a; action 1 blends cb and cr with the floor
// average of the four coverages.
module subtitle_alpha_blend_yuv
	import sab_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	output logic       busy,
	input  wire sab_item_t item,
	output logic       done,
	output sab_result_t result
);

	logic        accept;
	logic [9:0]  cov_sum;
	logic [7:0]  cov;
	sab_yuv_t    yuv_s2;

	logic        v_s1, v_s2, v_s3, v_s4, v_s5;
	logic        act_s1, act_s2, act_s3, act_s4;
	logic [7:0]  cov_s1, opac_s1;
	logic [15:0] wprod_s2;
	logic [7:0]  k_s3;
	sab_yuv_t    yuv_s3;
	logic [15:0] mix_a_s4, mix_b_s4;
	logic [23:0] pix_s1, pix_s2, pix_s3, pix_s4;
	sab_result_t result_s5;

	logic [7:0]  over_a, orig_a, inv_k;

	// the pipeline never stalls
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// overlay colour conversion, two stages
	sab_rgb2yuv u_rgb2yuv (
		.clk    (clk),
		.color  (item.overlay_color),
		.yuv_s2 (yuv_s2)
	);

	// coverage selection
	always_comb begin
		cov_sum = 10'(item.coverage_a) + 10'(item.coverage_b)
			+ 10'(item.coverage_c) + 10'(item.coverage_d);
		cov = (item.action == ACT_CHROMA) ? cov_sum[9:2] : item.coverage_a;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// stage 1: coverage and opacity
	always_ff @(posedge clk) begin
		act_s1  <= item.action;
		cov_s1  <= cov;
		opac_s1 <= BLEND_FULL - item.overlay_color[7:0];
		pix_s1  <= {item.pixel_luma, item.pixel_cb, item.pixel_cr};
	end

	// stage 2: coverage times opacity
	always_ff @(posedge clk) begin
		act_s2   <= act_s1;
		wprod_s2 <= 16'(cov_s1) * 16'(opac_s1);
		pix_s2   <= pix_s1;
	end

	// stage 3: effective weight
	always_ff @(posedge clk) begin
		act_s3 <= act_s2;
		k_s3   <= div255(wprod_s2);
		yuv_s3 <= yuv_s2;
		pix_s3 <= pix_s2;
	end

	// blend operands: path a is luma or cb, path b is cr
	always_comb begin
		inv_k  = BLEND_FULL - k_s3;
		over_a = (act_s3 == ACT_CHROMA) ? yuv_s3.u : yuv_s3.y;
		orig_a = (act_s3 == ACT_CHROMA) ? pix_s3[15:8] : pix_s3[23:16];
	end

	// stage 4: weighted sums
	always_ff @(posedge clk) begin
		act_s4   <= act_s3;
		mix_a_s4 <= 16'(k_s3) * 16'(over_a) + 16'(inv_k) * 16'(orig_a);
		mix_b_s4 <= 16'(k_s3) * 16'(yuv_s3.v) + 16'(inv_k) * 16'(pix_s3[7:0]);
		pix_s4   <= pix_s3;
	end

	// stage 5: divide down and merge with the untouched fields
	always_ff @(posedge clk) begin
		if (act_s4 == ACT_CHROMA) begin
			result_s5.out_luma <= pix_s4[23:16];
			result_s5.out_cb   <= div255(mix_a_s4);
			result_s5.out_cr   <= div255(mix_b_s4);
		end else begin
			result_s5.out_luma <= div255(mix_a_s4);
			result_s5.out_cb   <= pix_s4[15:8];
			result_s5.out_cr   <= pix_s4[7:0];
		end
	end

	assign done   = v_s5;
	assign result = result_s5;

endmodule
`default_nettype wire

>>> rtl/sab_checker.sv
`default_nettype none
module sab_checker
	import sab_pkg::*;
(
	input wire logic  clk,
	input wire logic  arst_n,
	input wire logic  start,
	input wire logic  busy,
	input wire sab_item_t   item,
	input wire logic  done,
	input wire sab_result_t result
);

	// no back-pressure on the input side
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

	// every beat taken gives a result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##5 done)
		else $error("result missing");

	// no result without a beat
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##5 !done)
		else $error("spurious result");

	// luma beat leaves chroma untouched
	a_luma_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.action == ACT_LUMA) |-> ##5
		(result.out_cb == $past(item.pixel_cb, 5)
		&& result.out_cr == $past(item.pixel_cr, 5)))
		else $error("chroma changed in luma beat");

	// chroma beat leaves luma untouched
	a_chroma_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.action == ACT_CHROMA) |-> ##5
		(result.out_luma == $past(item.pixel_luma, 5)))
		else $error("luma changed in chroma beat");

endmodule

bind subtitle_alpha_blend_yuv sab_checker u_sab_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.item   (item),
	.done   (done),
	.result (result)
);
`default_nettype wire

>>> tb/blend_checker.sv
`timescale 1ns / 100ps
// watches both channels of the overlay blend, predicts each result and compares
module blend_checker
	import sab_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  sab_item_t   item,
	input  logic        done,
	input  sab_result_t result,
	output int          errors,
	output int          pending
);

	sab_result_t blended_q[$];
	sab_result_t want;

	initial begin
		errors  = 0;
		pending = 0;
	end

	// one line per mismatch, counted
	task automatic report_mismatch(input string what, input logic [7:0] wanted,
			input logic [7:0] got);
		$display("mismatch at %0t: %s, wanted %0d got %0d", $time, what, wanted, got);
		errors++;
	endtask

	// weighted mix of overlay and original, truncated
	function automatic logic [7:0] mix_sample(input int k, input int over, input int orig);
		return 8'((k * over + (255 - k) * orig) / 255);
	endfunction

	// overlay colour to yuv, then blend by coverage times opacity
	function automatic sab_result_t blend_sample(input sab_item_t it);
		int r, g, bl, opac, cov, k, oy, ou, ov;
		sab_result_t res;
		r    = it.overlay_color[31:24];
		g    = it.overlay_color[23:16];
		bl   = it.overlay_color[15:8];
		opac = 255 - int'(it.overlay_color[7:0]);
		oy   = ((CY_R * r + CY_G * g + CY_B * bl) >>> 10) + 16;
		ou   = (((CU_R * r - CU_G * g - CU_B * bl) >>> 10) + 128) & 255;
		ov   = (((-CV_R * r - CV_G * g + CV_B * bl) >>> 10) + 128) & 255;
		res.out_luma = it.pixel_luma;
		res.out_cb   = it.pixel_cb;
		res.out_cr   = it.pixel_cr;
		if (it.action == ACT_LUMA) begin
			cov = it.coverage_a;
			k   = cov * opac / 255;
			res.out_luma = mix_sample(k, oy & 255, it.pixel_luma);
		end else begin
			// floor average of the four coverages of the 2x2 block
			cov = (int'(it.coverage_a) + int'(it.coverage_b) + int'(it.coverage_c)
				+ int'(it.coverage_d)) >> 2;
			k   = cov * opac / 255;
			res.out_cb = mix_sample(k, ou, it.pixel_cb);
			res.out_cr = mix_sample(k, ov, it.pixel_cr);
		end
		return res;
	endfunction

	// compare each result beat with the oldest prediction, then queue new beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blended_q.delete();
		end else begin
			if (done === 1'b1) begin
				if (blended_q.size() == 0) begin
					report_mismatch("result beat with nothing pending, luma", 8'd0,
						result.out_luma);
				end else begin
					want = blended_q.pop_front();
					if (result.out_luma !== want.out_luma)
						report_mismatch("out_luma", want.out_luma, result.out_luma);
					if (result.out_cb !== want.out_cb)
						report_mismatch("out_cb", want.out_cb, result.out_cb);
					if (result.out_cr !== want.out_cr)
						report_mismatch("out_cr", want.out_cr, result.out_cr);
				end
			end
			if (start === 1'b1 && busy === 1'b0)
				blended_q.push_back(blend_sample(item));
		end
		pending = blended_q.size();
	end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
module tb;
	import sab_pkg::*;

	localparam int N_RANDOM    = 1800;
	localparam int QUIET_FIRST = 700;
	localparam int QUIET_LAST  = 1100;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	sab_item_t   item;
	logic        done;
	sab_result_t result;
	int          errors;
	int          pending;
	int          n_luma = 0;
	int          n_chroma = 0;

	subtitle_alpha_blend_yuv u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	blend_checker u_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.done    (done),
		.result  (result),
		.errors  (errors),
		.pending (pending)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop
	initial begin
		#2ms;
		$display("timeout with %0d results outstanding", pending);
		$display("== FAIL ==");
		$finish;
	end

	function automatic sab_item_t mk(input logic act, input logic [31:0] col,
			input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
			input logic [7:0] d, input logic [7:0] y, input logic [7:0] u,
			input logic [7:0] v);
		sab_item_t it;
		it.action        = act;
		it.overlay_color = col;
		it.coverage_a    = a;
		it.coverage_b    = b;
		it.coverage_c    = c;
		it.coverage_d    = d;
		it.pixel_luma    = y;
		it.pixel_cb      = u;
		it.pixel_cr      = v;
		return it;
	endfunction

	// byte with extra weight on the extremes
	function automatic logic [7:0] rand_byte();
		case ($urandom_range(7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	// idle cycles, each one taken with a chance of 37 in 100, then hold the beat until taken
	task automatic drive_item(input sab_item_t it, input bit may_idle);
		while (may_idle && $urandom_range(99) < 37) begin
			start <= 1'b0;
			item  <= sab_item_t'($urandom);
			@(posedge clk);
		end
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy !== 1'b0);
		if (it.action == ACT_LUMA)
			n_luma++;
		else
			n_chroma++;
	endtask

	initial begin
		sab_item_t dir[$];
		sab_item_t it;
		arst_n <= 1'b0;
		start  <= 1'b0;
		item   <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: colour and coverage extremes, both actions, the unused and averaged coverage
		dir.push_back(mk(ACT_LUMA, 32'h0000_0000, 0, 0, 0, 0, 0, 0, 0));
		dir.push_back(mk(ACT_LUMA, 32'hFFFF_FF00, 255, 0, 0, 0, 0, 77, 200));
		dir.push_back(mk(ACT_LUMA, 32'hFFFF_FFFF, 255, 255, 255, 255, 255, 255, 255));
		dir.push_back(mk(ACT_LUMA, 32'h0000_0000, 255, 0, 0, 0, 255, 1, 2));
		dir.push_back(mk(ACT_LUMA, 32'hFFFF_FF00, 0, 255, 255, 255, 40, 50, 60));
		dir.push_back(mk(ACT_LUMA, 32'h8080_8080, 128, 7, 9, 11, 99, 130, 140));
		dir.push_back(mk(ACT_LUMA, 32'hFFFF_FF01, 255, 0, 0, 0, 0, 0, 0));
		dir.push_back(mk(ACT_LUMA, 32'hFFFF_FF00, 1, 0, 0, 0, 0, 0, 0));
		dir.push_back(mk(ACT_LUMA, 32'h1234_5678, 200, 3, 4, 5, 17, 222, 33));
		dir.push_back(mk(ACT_CHROMA, 32'hFF00_0000, 255, 255, 255, 255, 0, 0, 0));
		dir.push_back(mk(ACT_CHROMA, 32'h00FF_0000, 255, 255, 255, 255, 0, 255, 255));
		dir.push_back(mk(ACT_CHROMA, 32'h0000_FF00, 255, 255, 255, 255, 10, 0, 0));
		dir.push_back(mk(ACT_CHROMA, 32'hFFFF_FF00, 255, 255, 255, 255, 20, 128, 128));
		dir.push_back(mk(ACT_CHROMA, 32'h0000_0000, 0, 0, 0, 0, 255, 255, 255));
		dir.push_back(mk(ACT_CHROMA, 32'hFF00_0000, 255, 0, 0, 0, 5, 0, 255));
		dir.push_back(mk(ACT_CHROMA, 32'h00FF_0000, 255, 255, 255, 254, 6, 255, 0));
		dir.push_back(mk(ACT_CHROMA, 32'h0000_FF00, 1, 1, 1, 0, 7, 100, 100));
		dir.push_back(mk(ACT_CHROMA, 32'hFFFF_FFFF, 255, 255, 255, 255, 8, 3, 250));
		dir.push_back(mk(ACT_CHROMA, 32'h00FF_FF01, 255, 255, 255, 255, 9, 0, 0));
		dir.push_back(mk(ACT_CHROMA, 32'hFF00_FF00, 255, 255, 255, 255, 0, 255, 255));
		dir.push_back(mk(ACT_CHROMA, 32'h00FF_FF00, 128, 64, 32, 255, 255, 0, 255));
		foreach (dir[i])
			drive_item(dir[i], 1'b1);

		// random: extremes weighted, with a stretch of back-to-back beats
		for (int n = 0; n < N_RANDOM; n++) begin
			it.action        = $urandom_range(1) ? ACT_CHROMA : ACT_LUMA;
			it.overlay_color = {rand_byte(), rand_byte(), rand_byte(), rand_byte()};
			it.coverage_a    = rand_byte();
			it.coverage_b    = rand_byte();
			it.coverage_c    = rand_byte();
			it.coverage_d    = rand_byte();
			it.pixel_luma    = rand_byte();
			it.pixel_cb      = rand_byte();
			it.pixel_cr      = rand_byte();
			drive_item(it, !(n >= QUIET_FIRST && n < QUIET_LAST));
		end
		start <= 1'b0;

		// drain, then wait on for anything stray
		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("blended %0d luma samples and %0d chroma pairs, %0d mismatches",
			n_luma, n_chroma, errors);
		$display("colour, coverage and pixel extremes and random idle gaps exercised");
		if (errors == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/sab_pkg.sv
rtl/sab_rgb2yuv.sv
rtl/subtitle_alpha_blend_yuv.sv
rtl/sab_checker.sv
tb/blend_checker.sv
tb/tb.sv
